### sv/dfe_pkg.sv
// dimmer fade engine package: field widths, command and register codes, constants
// no dependencies; imported by the interfaces, the top level and the checker
`default_nettype none

package dfe_pkg;

   localparam int TICK_COUNT_WIDTH = 16;

   localparam int LEVEL_W    = 8;
   localparam int CMD_W      = 3;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // serial divider for the fade step: numerator shift register and iteration counter
   localparam int DIV_NUM_W      = 16;
   localparam int DIV_BYTE_STEPS = LEVEL_W;
   localparam int DIV_CNT_W      = $clog2(DIV_BYTE_STEPS + 1);

   // x / 100 as (x * 5243) >> 19, exact for x below 43690
   localparam int PCT_RECIP       = 5243;
   localparam int PCT_RECIP_SHIFT = 19;
   // (t * 100 + 127) / 255 with 1/255 as 32897 >> 23, exact for numerators below 66052
   localparam int RPT_SCALE       = 100;
   localparam int RPT_ROUND       = 127;
   localparam int RPT_RECIP       = 32897;
   localparam int RPT_RECIP_SHIFT = 23;
   localparam int RPT_MUL         = RPT_SCALE * RPT_RECIP;
   localparam int RPT_ADD         = RPT_ROUND * RPT_RECIP;

   typedef logic [LEVEL_W-1:0]          level_type;
   typedef logic [PCT_W-1:0]            percent_type;
   typedef logic [TICK_COUNT_WIDTH-1:0] ticks_type;
   typedef logic [DIV_NUM_W-1:0]        div_num_type;
   typedef logic [DIV_CNT_W-1:0]        div_cnt_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_ON          = 3'd1,
      CMD_OFF         = 3'd2,
      CMD_TOGGLE      = 3'd3,
      CMD_CYCLE_START = 3'd4,
      CMD_CYCLE_STOP  = 3'd5,
      CMD_SET_PERCENT = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_LEVEL_DEFAULT = 2'd0,
      CSR_ON_FADE_TICKS    = 2'd1,
      CSR_OFF_FADE_TICKS   = 2'd2,
      CSR_CYCLE_FADE_TICKS = 2'd3
   } csr_index_type;

   localparam level_type   LEVEL_FULL   = 8'd255;
   localparam level_type   LEVEL_OFF    = 8'd0;
   localparam percent_type PERCENT_FULL = 7'd100;

   // reset values of the configuration registers
   localparam level_type RST_ON_LEVEL_DEFAULT = 8'd255;
   localparam ticks_type RST_ON_FADE_TICKS    = TICK_COUNT_WIDTH'(0);
   localparam ticks_type RST_OFF_FADE_TICKS   = TICK_COUNT_WIDTH'(0);
   localparam ticks_type RST_CYCLE_FADE_TICKS = TICK_COUNT_WIDTH'(100);

endpackage

`default_nettype wire

### sv/dfe_ifs.sv
// valid/ready channel interfaces of the dimmer fade engine: request, response, csr write
// depends on dfe_pkg
`default_nettype none

interface dfe_req_if;
   import dfe_pkg::*;
   logic        valid;
   logic        ready;
   logic [CMD_W-1:0] cmd;
   percent_type percent;
   modport source (output valid, output cmd, output percent, input ready);
   modport sink   (input valid, input cmd, input percent, output ready);
endinterface

interface dfe_rsp_if;
   import dfe_pkg::*;
   logic        valid;
   logic        ready;
   level_type   level;
   logic        fading;
   logic        report_valid;
   percent_type report_percent;
   modport source (output valid, output level, output fading, output report_valid,
                   output report_percent, input ready);
   modport sink   (input valid, input level, input fading, input report_valid,
                   input report_percent, output ready);
endinterface

interface dfe_csr_if;
   import dfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/dimmer_fade_engine.sv
// dimmer fade engine top level: one 8-bit dimmer channel, commands and fade ticks
// depends on dfe_pkg and the channel interfaces in dfe_ifs.sv
//
//   channel  dir  transaction                          width
//   req      in   cmd, percent                         3 + 7
//   rsp      out  level, fading, report_valid,         8 + 1 + 1 + 7
//                 report_percent
//   csr      in   index, data (register write)         2 + 16
//
// one transaction at a time: req.ready is low from accept until the response is taken
// states after the accepting idle one: tick, unused code and stop cycling while not
//   cycling go to output; stop cycling via report; jumps via switch and report, set percent
//   first via percent; a fade start runs the serial divider for the step, one quotient bit
//   a cycle, in fade and step before report, and only cycling start skips switch
// a stalled response holds in the output stage and blocks the next request
// reset is synchronous; csr writes are always taken, one per cycle
`default_nettype none

module dimmer_fade_engine (
   input  wire logic  clock,
   input  wire logic  reset,
   dfe_req_if.sink    req,
   dfe_rsp_if.source  rsp,
   dfe_csr_if.sink    csr
);
   import dfe_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,    // waiting for a request
      S_PCT,     // percent to level conversion
      S_SWITCH,  // on or off: jump or start a fade
      S_FADE,    // set up the step divide
      S_STEP,    // step size divide
      S_RPT,     // report percent
      S_OUT      // response held until taken
   } state_type;

   state_type   state_ff, state_in;

   // configuration registers
   level_type   on_def_ff, on_def_in;
   ticks_type   on_ticks_ff, on_ticks_in;
   ticks_type   off_ticks_ff, off_ticks_in;
   ticks_type   cyc_ticks_ff, cyc_ticks_in;

   // channel state
   level_type   level_ff, level_in;
   level_type   on_target_ff, on_target_in;
   logic        fade_ff, fade_in;
   logic        cyc_ff, cyc_in;
   level_type   step_mag_ff, step_mag_in;
   logic        step_neg_ff, step_neg_in;
   ticks_type   ticks_left_ff, ticks_left_in;
   ticks_type   sweep_ff, sweep_in;
   level_type   end_ff, end_in;

   // per transaction
   level_type   tgt_ff, tgt_in;       // target level of the command
   logic        is_on_ff, is_on_in;
   logic        periodic_ff, periodic_in;
   ticks_type   cnt_ff, cnt_in;       // fade length in ticks
   logic        rpt_ff, rpt_in;
   percent_type rpt_pct_ff, rpt_pct_in;

   // shared serial divider
   div_num_type div_num_ff, div_num_in;   // numerator in, quotient out
   ticks_type   div_rem_ff, div_rem_in;
   ticks_type   div_dvs_ff, div_dvs_in;
   div_cnt_type div_cnt_ff, div_cnt_in;

   // divider iteration
   logic [TICK_COUNT_WIDTH:0] div_shift;
   logic [TICK_COUNT_WIDTH:0] div_diff;
   logic                      div_ge;
   logic                      div_done;
   level_type                 div_q;

   // tick arithmetic
   logic [LEVEL_W:0] up_sum;
   logic [LEVEL_W:0] dn_bound;
   level_type        dn_val;
   logic             tick_hit;
   logic             tick_last;

   // command decode
   cmd_type          cmd;
   percent_type      pct_sat;
   div_num_type      pct_num;
   logic             fade_up;

   // constant divides by reciprocal multiply
   logic [31:0]      pct_prod;
   level_type        pct_q;
   logic [31:0]      rpt_prod;
   percent_type      rpt_q;

   assign cmd      = cmd_type'(req.cmd);
   assign pct_sat  = (req.percent > PERCENT_FULL) ? PERCENT_FULL : req.percent;
   // p * 255 as (p << 8) - p
   assign pct_num  = {1'b0, pct_sat, 8'h00} - DIV_NUM_W'(pct_sat);
   assign fade_up  = is_on_ff && (tgt_ff > level_ff);

   // level = p * 255 / 100, p * 255 held in the divider numerator register
   assign pct_prod = 32'(div_num_ff) * 32'(PCT_RECIP);
   assign pct_q    = pct_prod[PCT_RECIP_SHIFT +: LEVEL_W];
   // percent = (target * 100 + 127) / 255, folded into one multiply-add
   assign rpt_prod = 32'(tgt_ff) * 32'(RPT_MUL) + 32'(RPT_ADD);
   assign rpt_q    = rpt_prod[RPT_RECIP_SHIFT +: PCT_W];

   assign div_shift = {div_rem_ff, div_num_ff[DIV_NUM_W-1]};
   assign div_diff  = div_shift - {1'b0, div_dvs_ff};
   assign div_ge    = div_shift >= {1'b0, div_dvs_ff};
   assign div_done  = (div_cnt_ff == '0);
   assign div_q     = div_num_ff[LEVEL_W-1:0];

   // one tick: add or subtract the step and clamp at the end level
   assign up_sum    = {1'b0, level_ff} + {1'b0, step_mag_ff};
   assign dn_bound  = {1'b0, end_ff} + {1'b0, step_mag_ff};
   assign dn_val    = level_ff - step_mag_ff;
   assign tick_hit  = step_neg_ff ? ({1'b0, level_ff} <= dn_bound)
                                  : (up_sum >= {1'b0, end_ff});
   assign tick_last = tick_hit || (ticks_left_ff == '0);

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid          = (state_ff == S_OUT);
   assign rsp.level          = level_ff;
   assign rsp.fading         = fade_ff;
   assign rsp.report_valid   = rpt_ff;
   assign rsp.report_percent = rpt_pct_ff;

   always_comb begin
      state_in      = state_ff;
      on_def_in     = on_def_ff;
      on_ticks_in   = on_ticks_ff;
      off_ticks_in  = off_ticks_ff;
      cyc_ticks_in  = cyc_ticks_ff;
      level_in      = level_ff;
      on_target_in  = on_target_ff;
      fade_in       = fade_ff;
      cyc_in        = cyc_ff;
      step_mag_in   = step_mag_ff;
      step_neg_in   = step_neg_ff;
      ticks_left_in = ticks_left_ff;
      sweep_in      = sweep_ff;
      end_in        = end_ff;
      tgt_in        = tgt_ff;
      is_on_in      = is_on_ff;
      periodic_in   = periodic_ff;
      cnt_in        = cnt_ff;
      rpt_in        = rpt_ff;
      rpt_pct_in    = rpt_pct_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_dvs_in    = div_dvs_ff;
      div_cnt_in    = div_cnt_ff;

      // csr writes; the user must issue them only while idle, the block does not enforce it
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_ON_LEVEL_DEFAULT: on_def_in    = csr.data[LEVEL_W-1:0];
            CSR_ON_FADE_TICKS:    on_ticks_in  = TICK_COUNT_WIDTH'(csr.data);
            CSR_OFF_FADE_TICKS:   off_ticks_in = TICK_COUNT_WIDTH'(csr.data);
            CSR_CYCLE_FADE_TICKS: cyc_ticks_in = TICK_COUNT_WIDTH'(csr.data);
         endcase
      end

      // divider step, one quotient bit shifted in per cycle
      if (!div_done) begin
         div_rem_in = div_ge ? div_diff[TICK_COUNT_WIDTH-1:0]
                             : div_shift[TICK_COUNT_WIDTH-1:0];
         div_num_in = {div_num_ff[DIV_NUM_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               rpt_in      = 1'b1;
               periodic_in = 1'b0;
               case (cmd)
                  CMD_TICK: begin
                     rpt_in     = 1'b0;
                     rpt_pct_in = '0;
                     state_in   = S_OUT;
                     if (fade_ff) begin
                        if (tick_last) begin
                           level_in = end_ff;
                           if (cyc_ff) begin
                              // reverse the sweep
                              ticks_left_in = sweep_ff;
                              step_neg_in   = !step_neg_ff;
                              end_in        = step_neg_ff ? LEVEL_FULL : LEVEL_OFF;
                           end else begin
                              ticks_left_in = '0;
                              fade_in       = 1'b0;
                           end
                        end else begin
                           level_in      = step_neg_ff ? dn_val : up_sum[LEVEL_W-1:0];
                           ticks_left_in = ticks_left_ff - 1'b1;
                        end
                     end
                  end
                  CMD_ON: begin
                     is_on_in = 1'b1;
                     tgt_in   = on_target_ff;
                     state_in = S_SWITCH;
                  end
                  CMD_OFF: begin
                     is_on_in = 1'b0;
                     tgt_in   = LEVEL_OFF;
                     state_in = S_SWITCH;
                  end
                  CMD_TOGGLE: begin
                     state_in = S_SWITCH;
                     if (level_ff != LEVEL_OFF) begin
                        // a downward fade in progress toggles back on
                        is_on_in = fade_ff && step_neg_ff;
                        tgt_in   = (fade_ff && step_neg_ff) ? on_target_ff : LEVEL_OFF;
                     end else begin
                        is_on_in = 1'b1;
                        if (on_target_ff == LEVEL_OFF) begin
                           on_target_in = on_def_ff;
                           tgt_in       = on_def_ff;
                        end else begin
                           tgt_in = on_target_ff;
                        end
                     end
                  end
                  CMD_CYCLE_START: begin
                     on_target_in = on_def_ff;
                     tgt_in       = on_def_ff;
                     is_on_in     = 1'b1;
                     periodic_in  = 1'b1;
                     cnt_in       = (cyc_ticks_ff == '0) ? TICK_COUNT_WIDTH'(1) : cyc_ticks_ff;
                     state_in     = S_FADE;
                  end
                  CMD_CYCLE_STOP: begin
                     if (cyc_ff) begin
                        fade_in      = 1'b0;
                        cyc_in       = 1'b0;
                        on_target_in = level_ff;
                        tgt_in       = level_ff;
                        state_in     = S_RPT;
                     end else begin
                        rpt_in     = 1'b0;
                        rpt_pct_in = '0;
                        state_in   = S_OUT;
                     end
                  end
                  CMD_SET_PERCENT: begin
                     div_num_in = pct_num;
                     state_in   = S_PCT;
                  end
                  default: begin
                     // unused code: no change, no report
                     rpt_in     = 1'b0;
                     rpt_pct_in = '0;
                     state_in   = S_OUT;
                  end
               endcase
            end
         end
         S_PCT: begin
            state_in = S_SWITCH;
            if (pct_q != LEVEL_OFF) begin
               on_target_in = pct_q;
               tgt_in       = pct_q;
               is_on_in     = 1'b1;
            end else begin
               tgt_in   = LEVEL_OFF;
               is_on_in = 1'b0;
            end
         end
         S_SWITCH: begin
            if (is_on_ff && (on_ticks_ff != '0)) begin
               cnt_in   = on_ticks_ff;
               state_in = S_FADE;
            end else if (!is_on_ff && (off_ticks_ff != '0)) begin
               cnt_in   = off_ticks_ff;
               state_in = S_FADE;
            end else begin
               // immediate jump, a running fade keeps running
               level_in = tgt_ff;
               state_in = S_RPT;
            end
         end
         S_FADE: begin
            // numerator sits in the top byte so 8 iterations give the quotient
            div_num_in  = {(fade_up ? tgt_ff : level_ff), 8'h00};
            div_dvs_in  = cnt_ff;
            div_rem_in  = '0;
            div_cnt_in  = DIV_CNT_W'(DIV_BYTE_STEPS);
            step_neg_in = !fade_up;
            end_in      = is_on_ff ? tgt_ff : LEVEL_OFF;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (div_done) begin
               step_mag_in   = (div_q == '0) ? LEVEL_W'(1) : div_q;
               fade_in       = 1'b1;
               cyc_in        = periodic_ff;
               ticks_left_in = cnt_ff;
               sweep_in      = cnt_ff;
               state_in      = S_RPT;
            end
         end
         S_RPT: begin
            rpt_pct_in = rpt_q;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         on_def_ff     <= RST_ON_LEVEL_DEFAULT;
         on_ticks_ff   <= RST_ON_FADE_TICKS;
         off_ticks_ff  <= RST_OFF_FADE_TICKS;
         cyc_ticks_ff  <= RST_CYCLE_FADE_TICKS;
         level_ff      <= LEVEL_OFF;
         on_target_ff  <= LEVEL_FULL;
         fade_ff       <= 1'b0;
         cyc_ff        <= 1'b0;
         step_mag_ff   <= '0;
         step_neg_ff   <= 1'b0;
         ticks_left_ff <= '0;
         sweep_ff      <= '0;
         end_ff        <= LEVEL_OFF;
         div_cnt_ff    <= '0;
         rpt_ff        <= 1'b0;
         rpt_pct_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         on_def_ff     <= on_def_in;
         on_ticks_ff   <= on_ticks_in;
         off_ticks_ff  <= off_ticks_in;
         cyc_ticks_ff  <= cyc_ticks_in;
         level_ff      <= level_in;
         on_target_ff  <= on_target_in;
         fade_ff       <= fade_in;
         cyc_ff        <= cyc_in;
         step_mag_ff   <= step_mag_in;
         step_neg_ff   <= step_neg_in;
         ticks_left_ff <= ticks_left_in;
         sweep_ff      <= sweep_in;
         end_ff        <= end_in;
         div_cnt_ff    <= div_cnt_in;
         rpt_ff        <= rpt_in;
         rpt_pct_ff    <= rpt_pct_in;
      end
      tgt_ff      <= tgt_in;
      is_on_ff    <= is_on_in;
      periodic_ff <= periodic_in;
      cnt_ff      <= cnt_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_dvs_ff  <= div_dvs_in;
   end

endmodule

`default_nettype wire

### sv/dfe_checker.sv
// port-level checks for the dimmer fade engine, bound to the top level
// depends on dfe_pkg and dimmer_fade_engine
`default_nettype none

module dfe_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_report_valid,
   input wire dfe_pkg::percent_type rsp_report_percent
);
   import dfe_pkg::*;

   // a pending response is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one transaction in flight: no request taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // engine goes busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine still ready after accept");

   // engine returns to ready once the response is taken
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("engine not ready after response taken");

   // percent is zero unless reported, and never above full scale
   a_report_percent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_report_valid ? (rsp_report_percent <= PERCENT_FULL)
                                      : (rsp_report_percent == '0)))
      else $error("bad report percent");

endmodule

bind dimmer_fade_engine dfe_checker u_dfe_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_report_valid   (rsp.report_valid),
   .rsp_report_percent (rsp.report_percent)
);

`default_nettype wire
